@@ rtl/dual_axis_incremental_pid_servo_macros.svh @@
// Assertion macros for the dual-axis incremental PID servo.
// Used by the port checker; needs nothing else.
`ifndef DUAL_AXIS_INCREMENTAL_PID_SERVO_MACROS_SVH
`define DUAL_AXIS_INCREMENTAL_PID_SERVO_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define DAPID_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define DAPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dapid_pkg.sv @@
// Shared types and constants of the dual-axis incremental PID servo.
// No dependencies; every other file but the assertion macros header imports this package.
`default_nettype none

package dapid_pkg;

  // Default fixed-point formats
  localparam int COEF_FRAC_BITS_DEF = 24;
  localparam int ACC_FRAC_BITS_DEF  = 20;

  // Field widths
  localparam int MEAS_W  = 16;
  localparam int DRIVE_W = 12;
  localparam int COEF_W  = 32;
  localparam int ERR_W   = MEAS_W + 1;
  localparam int DIFF_W  = ERR_W + 1;

  // Shared multiplier and the words around it
  localparam int OPA_W  = COEF_W + 1;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int MAG_W  = 2 * OPB_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int WIDE_W = COEF_W + MAG_W;

  // Increment magnitude limit
  localparam int INC_CAP_BITS = 40;
  localparam int INC_W        = INC_CAP_BITS + 1;

  // Deadband, rails and centre position
  localparam int DEADBAND = 10;
  localparam int X_MIN    = 500;
  localparam int X_MAX    = 2500;
  localparam int Y_MIN    = 900;
  localparam int Y_MAX    = 2100;
  localparam int CENTER   = 1500;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_TARGET_X,
    REG_TARGET_Y,
    REG_KP_X,
    REG_KP_Y,
    REG_KI_DT,
    REG_KD_DT,
    REG_OUT_GAIN
  } reg_e;

  typedef struct packed {
    logic [MEAS_W-1:0] target_x;
    logic [MEAS_W-1:0] target_y;
    logic [COEF_W-1:0] kp_x;
    logic [COEF_W-1:0] kp_y;
    logic [COEF_W-1:0] ki_dt;
    logic [COEF_W-1:0] kd_dt;
    logic [COEF_W-1:0] out_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_MAG,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_WIDE,
    ST_INC,
    ST_CLAMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic axis;
    logic do_err;
    logic do_mul_p;
    logic do_mul_d;
    logic do_sum;
    logic do_mag;
    logic do_gain_lo;
    logic do_gain_hi;
    logic do_wide;
    logic do_inc;
    logic do_clamp;
    logic do_out;
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/dapid_cfg.sv @@
// APB register file holding setpoints, coefficients and output gain.
// Depends on dapid_pkg.
`default_nettype none

module dapid_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dapid_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dapid_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dapid_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output dapid_pkg::cfg_t                  cfg_o
);
  import dapid_pkg::*;

  cfg_t cfg_q;
  reg_e reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_o   = cfg_q;

  // Write on the access phase of a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x <= MEAS_W'(400);
      cfg_q.target_y <= MEAS_W'(240);
      cfg_q.kp_x     <= COEF_W'(5872026);
      cfg_q.kp_y     <= COEF_W'(5872026);
      cfg_q.ki_dt    <= COEF_W'(17);
      cfg_q.kd_dt    <= COEF_W'(4529848);
      cfg_q.out_gain <= COEF_W'(503316);
    end else if (wr_en) begin
      case (reg_sel)
        REG_TARGET_X: cfg_q.target_x <= pwdata[MEAS_W-1:0];
        REG_TARGET_Y: cfg_q.target_y <= pwdata[MEAS_W-1:0];
        REG_KP_X:     cfg_q.kp_x     <= pwdata[COEF_W-1:0];
        REG_KP_Y:     cfg_q.kp_y     <= pwdata[COEF_W-1:0];
        REG_KI_DT:    cfg_q.ki_dt    <= pwdata[COEF_W-1:0];
        REG_KD_DT:    cfg_q.kd_dt    <= pwdata[COEF_W-1:0];
        REG_OUT_GAIN: cfg_q.out_gain <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      REG_TARGET_X: prdata = CFG_DATA_W'(cfg_q.target_x);
      REG_TARGET_Y: prdata = CFG_DATA_W'(cfg_q.target_y);
      REG_KP_X:     prdata = CFG_DATA_W'(cfg_q.kp_x);
      REG_KP_Y:     prdata = CFG_DATA_W'(cfg_q.kp_y);
      REG_KI_DT:    prdata = CFG_DATA_W'(cfg_q.ki_dt);
      REG_KD_DT:    prdata = CFG_DATA_W'(cfg_q.kd_dt);
      REG_OUT_GAIN: prdata = CFG_DATA_W'(cfg_q.out_gain);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dapid_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on dapid_pkg for operand widths.
`default_nettype none

module dapid_mul (
  input  logic                         clk_i,
  input  logic [dapid_pkg::OPA_W-1:0]  a_i,
  input  logic [dapid_pkg::OPB_W-1:0]  b_i,
  output logic [dapid_pkg::PROD_W-1:0] p_o
);
  import dapid_pkg::*;

  logic [PROD_W-1:0] p_q;

  // Register one product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/dapid_seq.sv @@
// Sequencer stepping both axes through the shared multiplier.
// Depends on dapid_pkg for the state and control types.
`default_nettype none

module dapid_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             skip_i,
  input  logic             out_free_i,
  output dapid_pkg::ctrl_t ctrl_o
);
  import dapid_pkg::*;

  state_e state_q, state_d;
  logic   axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // Next state: X axis first, then Y, then hand over the result
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ERR;
          axis_d  = 1'b0;
        end
      end
      ST_ERR: begin
        if (skip_i) begin
          state_d = axis_q ? ST_OUT : ST_ERR;
          axis_d  = 1'b1;
        end else begin
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P:   state_d = ST_MUL_D;
      ST_MUL_D:   state_d = ST_SUM;
      ST_SUM:     state_d = ST_MAG;
      ST_MAG:     state_d = ST_GAIN_LO;
      ST_GAIN_LO: state_d = ST_GAIN_HI;
      ST_GAIN_HI: state_d = ST_WIDE;
      ST_WIDE:    state_d = ST_INC;
      ST_INC:     state_d = ST_CLAMP;
      ST_CLAMP: begin
        state_d = axis_q ? ST_OUT : ST_ERR;
        axis_d  = 1'b1;
      end
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Decode the state into datapath enables
  always_comb begin
    ctrl_o      = '0;
    ctrl_o.axis = axis_q;
    case (state_q)
      ST_IDLE:    ctrl_o.in_ready   = 1'b1;
      ST_ERR:     ctrl_o.do_err     = 1'b1;
      ST_MUL_P:   ctrl_o.do_mul_p   = 1'b1;
      ST_MUL_D:   ctrl_o.do_mul_d   = 1'b1;
      ST_SUM:     ctrl_o.do_sum     = 1'b1;
      ST_MAG:     ctrl_o.do_mag     = 1'b1;
      ST_GAIN_LO: ctrl_o.do_gain_lo = 1'b1;
      ST_GAIN_HI: ctrl_o.do_gain_hi = 1'b1;
      ST_WIDE:    ctrl_o.do_wide    = 1'b1;
      ST_INC:     ctrl_o.do_inc     = 1'b1;
      ST_CLAMP:   ctrl_o.do_clamp   = 1'b1;
      ST_OUT:     ctrl_o.do_out     = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dual_axis_incremental_pid_servo.sv @@
// Dual-axis incremental PID servo: one PID step per axis for each measurement
// transfer, with a deadband of +/-10 counts around the setpoint. The work runs
// through one shared 33x25-bit multiplier under a small sequencer, four
// products per axis. An axis inside the deadband passes through ST_ERR only,
// an active axis through every state from ST_ERR to ST_CLAMP. The hand-over
// in ST_OUT waits while the previous result is still held on the output. The
// input is not ready while an item is in progress, but a new item is taken
// while the previous result still waits on the output register. Drive values
// are the integer parts of the Q12.ACC_FRAC_BITS accumulators, held to
// 500..2500 on X and 900..2100 on Y.
// Depends on dapid_pkg, dapid_cfg, dapid_mul and dapid_seq.
`default_nettype none

module dual_axis_incremental_pid_servo #(
  parameter int COEF_FRAC_BITS = dapid_pkg::COEF_FRAC_BITS_DEF,
  parameter int ACC_FRAC_BITS  = dapid_pkg::ACC_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Measurement stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] meas_x, [31:16] meas_y
  input  logic [2*dapid_pkg::MEAS_W-1:0]   s_axis_tdata,
  // Drive stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [11:0] drive_x, [23:12] drive_y
  output logic [2*dapid_pkg::DRIVE_W-1:0]  m_axis_tdata,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dapid_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dapid_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dapid_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import dapid_pkg::*;

  localparam int AccW     = DRIVE_W + ACC_FRAC_BITS;
  localparam int ShiftAmt = 2 * COEF_FRAC_BITS - ACC_FRAC_BITS;
  localparam int AccSumW  = ((AccW > INC_W) ? AccW : INC_W) + 2;

  localparam logic signed [ERR_W-1:0] DbHi = ERR_W'(DEADBAND);
  localparam logic signed [ERR_W-1:0] DbLo = -DbHi;
  localparam logic [INC_W-1:0] IncCap = {1'b1, {INC_CAP_BITS{1'b0}}};
  localparam logic [AccW-1:0] AccReset = {DRIVE_W'(CENTER), {ACC_FRAC_BITS{1'b0}}};
  localparam logic signed [AccSumW-1:0] XLo =
    AccSumW'({DRIVE_W'(X_MIN), {ACC_FRAC_BITS{1'b0}}});
  localparam logic signed [AccSumW-1:0] XHi =
    AccSumW'({DRIVE_W'(X_MAX), {ACC_FRAC_BITS{1'b0}}});
  localparam logic signed [AccSumW-1:0] YLo =
    AccSumW'({DRIVE_W'(Y_MIN), {ACC_FRAC_BITS{1'b0}}});
  localparam logic signed [AccSumW-1:0] YHi =
    AccSumW'({DRIVE_W'(Y_MAX), {ACC_FRAC_BITS{1'b0}}});

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  skip;
  logic  out_free;
  logic  in_fire;

  logic [MEAS_W-1:0]        meas_x_q, meas_y_q;
  logic signed [ERR_W-1:0]  last_x_q, last_y_q;
  logic [AccW-1:0]          acc_x_q, acc_y_q;
  logic [OPA_W-1:0]         opa_q;
  logic [OPB_W-1:0]         opb_q;
  logic [OPB_W-1:0]         mag_hi_q;
  logic [PROD_W-1:0]        prod;
  logic                     e_neg_q, d_neg_q, s_neg_q;
  logic [DIFF_W-2:0]        diff_abs_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [WIDE_W-1:0]        wide_q;
  logic signed [AccSumW-1:0] acc_sum_q;
  logic [DRIVE_W-1:0]       drive_x_q, drive_y_q;
  logic                     m_valid_q;

  logic [MEAS_W-1:0]        target_sel, meas_sel;
  logic [COEF_W-1:0]        kp_sel;
  logic signed [ERR_W-1:0]  last_sel, err, err_abs;
  logic signed [DIFF_W-1:0] diff, diff_abs;
  logic signed [SUM_W-1:0]  term, sum_abs;
  logic [MAG_W-1:0]         mag;
  logic [WIDE_W-1:0]        shifted;
  logic [INC_W-1:0]         inc;
  logic [AccW-1:0]          acc_sel;
  logic signed [AccSumW-1:0] acc_ext, inc_ext, lo_sel, hi_sel, acc_clamped;

  dapid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dapid_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .skip_i     (skip),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  dapid_mul u_mul (
    .clk_i (clk_i),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .p_o   (prod)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // Select the operands of the axis in progress
  assign target_sel = ctrl.axis ? cfg.target_y : cfg.target_x;
  assign meas_sel   = ctrl.axis ? meas_y_q : meas_x_q;
  assign kp_sel     = ctrl.axis ? cfg.kp_y : cfg.kp_x;
  assign last_sel   = ctrl.axis ? last_y_q : last_x_q;
  assign acc_sel    = ctrl.axis ? acc_y_q : acc_x_q;
  assign lo_sel     = ctrl.axis ? YLo : XLo;
  assign hi_sel     = ctrl.axis ? YHi : XHi;

  // Error, error change and the deadband test
  assign err      = $signed({1'b0, target_sel}) - $signed({1'b0, meas_sel});
  assign diff     = DIFF_W'(err) - DIFF_W'(last_sel);
  assign err_abs  = err[ERR_W-1] ? -err : err;
  assign diff_abs = diff[DIFF_W-1] ? -diff : diff;
  assign skip     = err inside {[DbLo:DbHi]};

  // Product as a signed term, and the magnitude of the PID sum
  assign term    = $signed(SUM_W'(prod));
  assign sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign mag     = sum_abs[MAG_W-1:0];

  // Rescale the increment and limit its magnitude
  assign shifted = wide_q >> ShiftAmt;
  assign inc     = (shifted > WIDE_W'(IncCap)) ? IncCap : shifted[INC_W-1:0];
  assign acc_ext = $signed(AccSumW'(acc_sel));
  assign inc_ext = $signed(AccSumW'(inc));

  // Hold the accumulator between its rails
  always_comb begin
    if (acc_sum_q < lo_sel) begin
      acc_clamped = lo_sel;
    end else if (acc_sum_q > hi_sel) begin
      acc_clamped = hi_sel;
    end else begin
      acc_clamped = acc_sum_q;
    end
  end

  // Axis state: accumulators and last errors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q  <= AccReset;
      acc_y_q  <= AccReset;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      if (ctrl.do_err && !skip) begin
        if (ctrl.axis) begin
          last_y_q <= err;
        end else begin
          last_x_q <= err;
        end
      end
      if (ctrl.do_clamp) begin
        if (ctrl.axis) begin
          acc_y_q <= acc_clamped[AccW-1:0];
        end else begin
          acc_x_q <= acc_clamped[AccW-1:0];
        end
      end
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_x_q <= s_axis_tdata[MEAS_W-1:0];
      meas_y_q <= s_axis_tdata[2*MEAS_W-1:MEAS_W];
    end
    if (ctrl.do_err && !skip) begin
      opa_q      <= OPA_W'(kp_sel) + OPA_W'(cfg.ki_dt);
      opb_q      <= OPB_W'(err_abs[MEAS_W-1:0]);
      e_neg_q    <= err[ERR_W-1];
      d_neg_q    <= diff[DIFF_W-1];
      diff_abs_q <= diff_abs[DIFF_W-2:0];
    end
    if (ctrl.do_mul_p) begin
      opa_q <= OPA_W'(cfg.kd_dt);
      opb_q <= OPB_W'(diff_abs_q);
    end
    if (ctrl.do_mul_d) begin
      sum_q <= e_neg_q ? -term : term;
    end
    if (ctrl.do_sum) begin
      sum_q <= sum_q + (d_neg_q ? -term : term);
    end
    if (ctrl.do_mag) begin
      opa_q    <= OPA_W'(cfg.out_gain);
      opb_q    <= mag[OPB_W-1:0];
      mag_hi_q <= mag[MAG_W-1:OPB_W];
      s_neg_q  <= sum_q[SUM_W-1];
    end
    if (ctrl.do_gain_lo) begin
      opb_q <= mag_hi_q;
    end
    if (ctrl.do_gain_hi) begin
      wide_q <= WIDE_W'(prod);
    end
    if (ctrl.do_wide) begin
      wide_q <= wide_q + WIDE_W'({prod, {OPB_W{1'b0}}});
    end
    if (ctrl.do_inc) begin
      acc_sum_q <= s_neg_q ? (acc_ext - inc_ext) : (acc_ext + inc_ext);
    end
    if (ctrl.do_out && out_free) begin
      drive_x_q <= acc_x_q[AccW-1 -: DRIVE_W];
      drive_y_q <= acc_y_q[AccW-1 -: DRIVE_W];
    end
  end

  // Output register: load on hand-over, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.do_out && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {drive_y_q, drive_x_q};

endmodule

`default_nettype wire

@@ rtl/dapid_chk.sv @@
// Port checker for the dual-axis incremental PID servo, bound to the top level.
// Depends on dapid_pkg and the assertion macros header.
`default_nettype none

`include "dual_axis_incremental_pid_servo_macros.svh"

module dapid_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [2*dapid_pkg::DRIVE_W-1:0] m_axis_tdata
);
  import dapid_pkg::*;

  // Drive values stay between their rails
  `DAPID_ASSERT_NOW(a_x_rails, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[DRIVE_W-1:0] >= DRIVE_W'(X_MIN)) && (m_axis_tdata[DRIVE_W-1:0] <= DRIVE_W'(X_MAX)), "drive_x outside its rails")
  `DAPID_ASSERT_NOW(a_y_rails, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[2*DRIVE_W-1:DRIVE_W] >= DRIVE_W'(Y_MIN)) && (m_axis_tdata[2*DRIVE_W-1:DRIVE_W] <= DRIVE_W'(Y_MAX)), "drive_y outside its rails")

  // One item at a time: busy right after an input transfer
  `DAPID_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready straight after a transfer")

  // A stalled result holds
  `DAPID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind dual_axis_incremental_pid_servo dapid_chk u_dapid_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ verif/tb_dual_axis_incremental_pid_servo.sv @@
// Self-checking testbench for the dual-axis incremental PID servo: predicts each drive
// transfer from a local copy of the gains, errors and accumulators and compares it.
// Depends on dapid_pkg and the dual_axis_incremental_pid_servo RTL.
`default_nettype none

module tb_dual_axis_incremental_pid_servo;
  timeunit 1ns;
  timeprecision 1ps;

  import dapid_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 210;
  localparam int INC_SHIFT      = 2 * COEF_FRAC_BITS_DEF - ACC_FRAC_BITS_DEF;
  localparam int AXIS_X         = 0;
  localparam int AXIS_Y         = 1;
  // Index just past the register map; writes there must be ignored
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_e;

  typedef struct packed {
    logic [MEAS_W-1:0] meas_y;
    logic [MEAS_W-1:0] meas_x;
  } meas_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_y;
    logic [DRIVE_W-1:0] drive_x;
  } drive_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*MEAS_W-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*DRIVE_W-1:0]  m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Servo state as seen by the predictor
  cfg_t   servo_cfg;
  longint pwm_accum [2];
  int     last_err  [2];

  meas_t  meas_pending [$];
  drive_t drive_expected [$];

  int     mismatch_count = 0;
  int     burst_left     = 1;
  int     gap_left       = 0;
  int     stall_span     = 0;
  stall_e stall_mode     = STALL_NONE;
  int     quiet_cycles   = 0;

  dual_axis_incremental_pid_servo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // One incremental PID step on one axis; inside the deadband nothing moves
  function automatic void axis_advance(int axis, logic [MEAS_W-1:0] target,
                                       logic [MEAS_W-1:0] meas, logic [COEF_W-1:0] kp,
                                       int rail_lo, int rail_hi);
    int           tgt_i;
    int           meas_i;
    int           err;
    longint       kp_l;
    longint       ki_l;
    longint       kd_l;
    longint       pid_sum;
    longint       step_inc;
    longint       lo_acc;
    longint       hi_acc;
    logic [63:0]  mag;
    logic [127:0] scaled;
    tgt_i  = target;
    meas_i = meas;
    err    = tgt_i - meas_i;
    if (err >= -DEADBAND && err <= DEADBAND) return;
    kp_l    = kp;
    ki_l    = servo_cfg.ki_dt;
    kd_l    = servo_cfg.kd_dt;
    pid_sum = (kp_l + ki_l) * err + kd_l * (err - last_err[axis]);
    last_err[axis] = err;
    // Scale the magnitude once, truncate, and cap far beyond the rails
    mag    = (pid_sum < 0) ? -pid_sum : pid_sum;
    scaled = {64'd0, mag} * {96'd0, servo_cfg.out_gain};
    scaled = scaled >> INC_SHIFT;
    if (scaled > (128'd1 << INC_CAP_BITS)) scaled = 128'd1 << INC_CAP_BITS;
    step_inc = scaled[63:0];
    if (pid_sum < 0) step_inc = -step_inc;
    lo_acc = rail_lo;
    hi_acc = rail_hi;
    lo_acc = lo_acc <<< ACC_FRAC_BITS_DEF;
    hi_acc = hi_acc <<< ACC_FRAC_BITS_DEF;
    pwm_accum[axis] = pwm_accum[axis] + step_inc;
    if (pwm_accum[axis] < lo_acc) pwm_accum[axis] = lo_acc;
    if (pwm_accum[axis] > hi_acc) pwm_accum[axis] = hi_acc;
  endfunction

  function automatic drive_t servo_step(meas_t m);
    drive_t d;
    longint whole_x;
    longint whole_y;
    axis_advance(AXIS_X, servo_cfg.target_x, m.meas_x, servo_cfg.kp_x, X_MIN, X_MAX);
    axis_advance(AXIS_Y, servo_cfg.target_y, m.meas_y, servo_cfg.kp_y, Y_MIN, Y_MAX);
    whole_x   = pwm_accum[AXIS_X] >>> ACC_FRAC_BITS_DEF;
    whole_y   = pwm_accum[AXIS_Y] >>> ACC_FRAC_BITS_DEF;
    d.drive_x = whole_x[DRIVE_W-1:0];
    d.drive_y = whole_y[DRIVE_W-1:0];
    return d;
  endfunction

  // Measurement driver: bursts of random length with random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (meas_pending.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= meas_pending.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive receiver: stall pattern changes at random intervals
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= stall_e'($urandom_range(0, 2));
      stall_span <= $urandom_range(16, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE: m_axis_tready <= 1'b1;
      STALL_HALF: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: check each drive transfer, predict on each measurement transfer
  always @(posedge clk_i) begin : drive_monitor
    drive_t got;
    drive_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (drive_expected.size() == 0) begin
          $display("%0t: unexpected drive transfer, expected none, actual x=%0d y=%0d",
                   $time, got.drive_x, got.drive_y);
          mismatch_count++;
        end else begin
          want = drive_expected.pop_front();
          if (got.drive_x != want.drive_x) begin
            $display("%0t: drive_x mismatch, expected %0d, actual %0d",
                     $time, want.drive_x, got.drive_x);
            mismatch_count++;
          end
          if (got.drive_y != want.drive_y) begin
            $display("%0t: drive_y mismatch, expected %0d, actual %0d",
                     $time, want.drive_y, got.drive_y);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) drive_expected.push_back(servo_step(s_axis_tdata));
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d drive transfers outstanding",
               $time, drive_expected.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_meas(int x, int y);
    meas_t m;
    m.meas_x = x[MEAS_W-1:0];
    m.meas_y = y[MEAS_W-1:0];
    meas_pending.push_back(m);
  endtask

  // Hold until every pending measurement is sent and every drive value is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (meas_pending.size() != 0 || s_axis_tvalid || drive_expected.size() != 0);
  endtask

  // Register write, then read back where the index is mapped
  task automatic cfg_write(logic [2:0] index, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] stored;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    stored  = value;
    case (index)
      REG_TARGET_X: begin
        servo_cfg.target_x = value[MEAS_W-1:0];
        stored             = {16'd0, value[MEAS_W-1:0]};
      end
      REG_TARGET_Y: begin
        servo_cfg.target_y = value[MEAS_W-1:0];
        stored             = {16'd0, value[MEAS_W-1:0]};
      end
      REG_KP_X:     servo_cfg.kp_x     = value;
      REG_KP_Y:     servo_cfg.kp_y     = value;
      REG_KI_DT:    servo_cfg.ki_dt    = value;
      REG_KD_DT:    servo_cfg.kd_dt    = value;
      REG_OUT_GAIN: servo_cfg.out_gain = value;
      default: ;
    endcase
    if (index != REG_UNMAPPED) begin
      @(posedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      if (prdata != stored) begin
        $display("%0t: readback mismatch at index %0d, expected %h, actual %h",
                 $time, index, stored, prdata);
        mismatch_count++;
      end
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Mostly moderate gains, now and then zero, full scale or anything at all
  function automatic logic [COEF_W-1:0] pick_coef(int unsigned typical_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, typical_max);
    endcase
  endfunction

  // Measurement near the setpoint, on the deadband edge, or anywhere
  function automatic int meas_around(logic [MEAS_W-1:0] target);
    int m;
    m = target;
    case ($urandom_range(0, 9))
      0, 1:    m = m + $urandom_range(0, 24) - 12;
      2:       m = $urandom_range(0, 65535);
      default: m = m + $urandom_range(0, 600) - 300;
    endcase
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    return m;
  endfunction

  initial begin
    servo_cfg.target_x = 16'd400;
    servo_cfg.target_y = 16'd240;
    servo_cfg.kp_x     = 32'd5872026;
    servo_cfg.kp_y     = 32'd5872026;
    servo_cfg.ki_dt    = 32'd17;
    servo_cfg.kd_dt    = 32'd4529848;
    servo_cfg.out_gain = 32'd503316;
    pwm_accum[AXIS_X]  = longint'(CENTER) <<< ACC_FRAC_BITS_DEF;
    pwm_accum[AXIS_Y]  = longint'(CENTER) <<< ACC_FRAC_BITS_DEF;
    last_err[AXIS_X]   = 0;
    last_err[AXIS_Y]   = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains: on target, deadband edges, both rails, alternating bits
    @(negedge clk_i);
    queue_meas(400, 240);
    queue_meas(410, 230);
    queue_meas(390, 250);
    queue_meas(389, 251);
    queue_meas(411, 229);
    queue_meas(0, 0);
    queue_meas(0, 0);
    queue_meas(0, 0);
    queue_meas(65535, 65535);
    queue_meas(0, 0);
    queue_meas(65535, 0);
    queue_meas(0, 65535);
    queue_meas(16'hAAAA, 16'h5555);
    queue_meas(16'h5555, 16'hAAAA);
    wait_drained();

    // Full-scale gains and extreme setpoints: increments hit the cap
    cfg_write(REG_TARGET_X, 32'h0000_FFFF);
    cfg_write(REG_TARGET_Y, 32'hFFFF_0000);
    cfg_write(REG_KP_X, '1);
    cfg_write(REG_KP_Y, '1);
    cfg_write(REG_KI_DT, '1);
    cfg_write(REG_KD_DT, '1);
    cfg_write(REG_OUT_GAIN, '1);
    @(negedge clk_i);
    queue_meas(0, 65535);
    queue_meas(65535, 0);
    queue_meas(65535, 65535);
    queue_meas(0, 0);
    queue_meas(65524, 11);
    queue_meas(65526, 10);
    wait_drained();

    // Zero gains: nothing moves but the last error still follows
    cfg_write(REG_TARGET_X, 32'd1000);
    cfg_write(REG_TARGET_Y, 32'd2000);
    cfg_write(REG_KP_X, '0);
    cfg_write(REG_KP_Y, '0);
    cfg_write(REG_KI_DT, '0);
    cfg_write(REG_KD_DT, '0);
    cfg_write(REG_OUT_GAIN, '0);
    cfg_write(REG_UNMAPPED, '1);
    @(negedge clk_i);
    queue_meas(0, 0);
    queue_meas(1000, 2000);
    queue_meas(2000, 1000);
    queue_meas(1011, 1989);
    wait_drained();

    // Random settings, each followed by a stretch of random measurements
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      cfg_write(REG_TARGET_X, $urandom);
      cfg_write(REG_TARGET_Y, $urandom);
      cfg_write(REG_KP_X, pick_coef(32'h0400_0000));
      cfg_write(REG_KP_Y, pick_coef(32'h0400_0000));
      cfg_write(REG_KI_DT, pick_coef(32'h0010_0000));
      cfg_write(REG_KD_DT, pick_coef(32'h0400_0000));
      cfg_write(REG_OUT_GAIN, pick_coef(32'h0040_0000));
      @(negedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_meas(meas_around(servo_cfg.target_x), meas_around(servo_cfg.target_y));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
